[rtl/core/b64se_pkg.sv]
// Shared types, constants and the character map of the base64 stream encoder.
package b64se_pkg;

  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar = 8'h3d;

  localparam logic [1:0] LastSlot = 2'd3;

  // One encode request: three bytes (zero-filled), number of '=' pads, end flag.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  npad;
    logic        last;
  } b64se_group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sextet_char = 8'h41 + w;
    end else if (v < 6'd52) begin
      sextet_char = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      sextet_char = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      sextet_char = 8'h2b;
    end else begin
      sextet_char = 8'h2f;
    end
  endfunction

endpackage

[rtl/core/b64se_front.sv]
// Front end: collects input bytes into groups and issues encode requests.
module b64se_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // end_of_message
  output logic                   req_valid,
  input  logic                   req_ready,
  output b64se_pkg::b64se_group_t req
);

  logic [1:0] fill_r, fill_nxt;
  logic [7:0] held0_r, held1_r;
  logic       accept;
  logic       emit;
  logic [7:0] b0, b1, b2;

  assign in_tready = req_ready;
  assign accept    = in_tvalid && in_tready;
  // A group goes out on its third byte or on the message end.
  assign emit      = (fill_r == 2'd2) || in_tlast;
  assign req_valid = accept && emit;

  always_comb begin
    b0 = in_tdata;
    b1 = 8'h00;
    b2 = 8'h00;
    req.npad = 2'd2;
    case (fill_r)
      2'd0: begin
        req.npad = 2'd2;
      end
      2'd1: begin
        b0 = held0_r;
        b1 = in_tdata;
        req.npad = 2'd1;
      end
      default: begin
        b0 = held0_r;
        b1 = held1_r;
        b2 = in_tdata;
        req.npad = 2'd0;
      end
    endcase
    req.bits = {b0, b1, b2};
    req.last = in_tlast;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = emit ? 2'd0 : fill_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Hold pending bytes; zero-fill is applied when the group is issued.
  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      if (fill_r == 2'd0) begin
        held0_r <= in_tdata;
      end else begin
        held1_r <= in_tdata;
      end
    end
  end

endmodule

[rtl/core/b64se_queue.sv]
// Short request queue between the front end and the character back end.
module b64se_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  b64se_pkg::b64se_group_t push_data,
  output logic                   not_full,
  input  logic                   pop,
  output logic                   not_empty,
  output b64se_pkg::b64se_group_t pop_data
);

  b64se_pkg::b64se_group_t              mem_r [b64se_pkg::QDepth];
  logic [b64se_pkg::QPtrW-1:0]          wr_ptr_r, rd_ptr_r;
  logic [b64se_pkg::QCountW-1:0]        count_r;
  logic                                 do_push, do_pop;

  localparam logic [b64se_pkg::QPtrW-1:0]   PtrMax  = b64se_pkg::QPtrW'(b64se_pkg::QDepth - 1);
  localparam logic [b64se_pkg::QCountW-1:0] CountMax = b64se_pkg::QCountW'(b64se_pkg::QDepth);

  assign not_full  = (count_r != CountMax);
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/b64se_back.sv]
// Back end: turns each encode request into four characters on the output register.
module b64se_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_pop,
  input  b64se_pkg::b64se_group_t req,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_char
  output logic                   out_tlast   // out_last
);

  b64se_pkg::b64se_group_t cur_r;
  logic                    cur_vld_r;
  logic [1:0]              idx_r;
  logic                    out_vld_r;
  logic [7:0]              out_char_r;
  logic                    out_last_r;
  logic                    load;
  logic                    at_end;
  logic [5:0]              sextet;
  logic [7:0]              char_nxt;
  logic [2:0]              data_cnt;

  assign load    = cur_vld_r && (!out_vld_r || out_tready);
  assign at_end  = (idx_r == b64se_pkg::LastSlot);
  assign req_pop = req_valid && (!cur_vld_r || (load && at_end));

  always_comb begin
    case (idx_r)
      2'd0:    sextet = cur_r.bits[23:18];
      2'd1:    sextet = cur_r.bits[17:12];
      2'd2:    sextet = cur_r.bits[11:6];
      default: sextet = cur_r.bits[5:0];
    endcase
    data_cnt = 3'd4 - {1'b0, cur_r.npad};
    char_nxt = ({1'b0, idx_r} < data_cnt) ? b64se_pkg::sextet_char(sextet)
                                           : b64se_pkg::PadChar;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (req_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 2'd0;
      end else if (load) begin
        cur_vld_r <= !at_end;
        idx_r     <= idx_r + 2'd1;
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      cur_r <= req;
    end
    if (load) begin
      out_char_r <= char_nxt;
      out_last_r <= at_end && cur_r.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/base64_stream_encoder.sv]
// Top level of the padded base64 stream encoder.
// Bytes enter on in_* with in_tlast marking the last byte of a message; every
// third byte, or the last byte of a message, issues a group that comes out as
// four ASCII characters on out_*, with '=' pads for a short final group and
// out_tlast on the final character of the message. An input byte is taken
// whenever the two-entry group queue has room; the output register sends
// one character per cycle while out_tready is high, so the single character
// output port sets the sustained rate: four characters per three bytes.
// A message ending with no bytes produces nothing.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast   // out_last
);

  b64se_pkg::b64se_group_t front_req;
  b64se_pkg::b64se_group_t back_req;
  logic                    front_valid;
  logic                    q_not_full;
  logic                    q_not_empty;
  logic                    back_pop;

  b64se_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .req_valid (front_valid),
    .req_ready (q_not_full),
    .req       (front_req)
  );

  b64se_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_req),
    .not_full  (q_not_full),
    .pop       (back_pop),
    .not_empty (q_not_empty),
    .pop_data  (back_req)
  );

  b64se_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (q_not_empty),
    .req_pop    (back_pop),
    .req        (back_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/core/b64se_checker.sv]
// Port-level checker for the base64 stream encoder, bound to the top level.
module b64se_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Output register is empty right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Stalled character holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // A pad that is not the final character is followed at once by the final pad.
  a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast && out_tdata == b64se_pkg::PadChar
    |=> out_tvalid && out_tlast && out_tdata == b64se_pkg::PadChar)
    else $error("first pad not followed by final pad");

  // The final character of a message is never a zero byte.
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata != 8'h00)
    else $error("final character is empty");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (.*);
